FILE: src/rte_pkg.sv
`timescale 1ns / 1ps

package rte_pkg;

    localparam int CS_W = 3;

    localparam logic [CS_W-1:0] CS_SRGB        = 3'd0;
    localparam logic [CS_W-1:0] CS_ADOBE       = 3'd1;
    localparam logic [CS_W-1:0] CS_PROPHOTO    = 3'd2;
    localparam logic [CS_W-1:0] CS_BT2020      = 3'd3;
    localparam logic [CS_W-1:0] CS_ACES        = 3'd4;
    localparam logic [CS_W-1:0] CS_LINEAR_SRGB = 3'd5;

    localparam int LOG_FRAC = 30;
    localparam int MANT_W   = LOG_FRAC + 1;
    localparam int LG_INT_W = 7;
    localparam int LG_W     = LG_INT_W + LOG_FRAC;
    localparam int EXP_W    = 26;
    localparam int MULQ_W   = 24;
    localparam int CONST_W  = 29;

    localparam logic [MANT_W-1:0] ONE_Q30 = 31'h4000_0000;

    localparam logic [EXP_W-1:0] E_SRGB     = 26'd27962027;
    localparam logic [EXP_W-1:0] E_PROPHOTO = 26'd37282702;
    localparam logic [EXP_W-1:0] E_BT2020   = 26'd30198989;
    localparam logic [EXP_W-1:0] E_ADOBE    = 26'd30514865;

    localparam logic [CONST_W-1:0] M_1292 = 29'd216761631;
    localparam logic [CONST_W-1:0] M_1055 = 29'd17699963;
    localparam logic [CONST_W-1:0] M_1099 = 29'd18438160;
    localparam logic [CONST_W-1:0] M_45   = 29'd75497472;
    localparam logic [CONST_W-1:0] M_16   = 29'd268435456;
    localparam logic [CONST_W-1:0] M_ONE  = 29'd16777216;

    localparam logic [63:0] K_SRGB_T   = 64'd3442351004;
    localparam logic [63:0] K_SRGB_OFF = 64'd60473139528;
    localparam logic [63:0] K_BT_T     = 64'd19791209300;
    localparam logic [63:0] K_BT_OFF   = 64'd108851651150;

    typedef struct packed {
        logic valid;
        logic pos;
    } rte_ctl_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] xx;
        logic [63:0] res;
        logic [63:0] b;
        xx  = x;
        res = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (xx >= res + b) begin
                xx  = xx - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [MANT_W-1:0] exp_tab_entry(input int k);
        logic [63:0] t;
        t = 64'd1 << (LOG_FRAC + 1);
        for (int i = 1; i <= LOG_FRAC; i++) begin
            if (i <= k) begin
                t = isqrt64(t << LOG_FRAC);
            end
        end
        return t[MANT_W-1:0];
    endfunction

    function automatic logic signed [63:0] kscale(input logic [63:0] c40, input int fb);
        int          sh;
        logic [63:0] r;
        sh = 40 - fb;
        if (sh <= 0) begin
            r = c40;
        end else begin
            r = (c40 + (64'd1 << (sh - 1))) >> sh;
        end
        return signed'(r);
    endfunction

    function automatic logic [EXP_W-1:0] power_exp(input logic [CS_W-1:0] cs);
        logic [EXP_W-1:0] e;
        case (cs)
            CS_ADOBE:    e = E_ADOBE;
            CS_PROPHOTO: e = E_PROPHOTO;
            CS_BT2020:   e = E_BT2020;
            default:     e = E_SRGB;
        endcase
        return e;
    endfunction

endpackage

FILE: src/rte_log2.sv
`timescale 1ns / 1ps

module rte_log2 #(
    parameter int SAMPLE_BITS = 32,
    parameter int FRAC_BITS   = 28
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  rte_pkg::rte_ctl_t                    ctl_in,
    input  logic signed [SAMPLE_BITS-1:0]        x_in,
    output rte_pkg::rte_ctl_t                    ctl_out,
    output logic signed [SAMPLE_BITS-1:0]        x_out,
    output logic signed [rte_pkg::LG_W-1:0]      lg_out
);
    import rte_pkg::*;

    localparam int PBITS = $clog2(SAMPLE_BITS);
    localparam int NSTG  = LOG_FRAC;
    localparam int NW    = SAMPLE_BITS + LOG_FRAC;

    logic [PBITS-1:0]             msb_pos;
    rte_ctl_t                     ctl_n1_reg;
    logic signed [SAMPLE_BITS-1:0] x_n1_reg;
    logic [PBITS-1:0]             p_n1_reg;
    logic [NW-1:0]                norm_wide;

    rte_ctl_t                      ctl_reg  [0:NSTG];
    logic signed [SAMPLE_BITS-1:0] x_reg    [0:NSTG];
    logic [MANT_W-1:0]             m_reg    [0:NSTG];
    logic [LOG_FRAC-1:0]           frac_reg [0:NSTG];
    logic [PBITS-1:0]              p_reg    [0:NSTG];

    logic [LG_INT_W-1:0] pdiff;

    always_comb begin
        msb_pos = '0;
        for (int i = 0; i < SAMPLE_BITS; i++) begin
            if (x_in[i]) begin
                msb_pos = PBITS'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_n1_reg <= '0;
        end else if (en) begin
            ctl_n1_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_n1_reg <= x_in;
            p_n1_reg <= msb_pos;
        end
    end

    assign norm_wide = {x_n1_reg, {LOG_FRAC{1'b0}}} >> p_n1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg[0] <= '0;
        end else if (en) begin
            ctl_reg[0] <= ctl_n1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x_n1_reg;
            m_reg[0]    <= norm_wide[MANT_W-1:0];
            frac_reg[0] <= '0;
            p_reg[0]    <= p_n1_reg;
        end
    end

    for (genvar g = 0; g < NSTG; g++) begin : g_sq
        logic [2*MANT_W-1:0]  sq;
        logic [MANT_W:0]      sh;
        logic [MANT_W-1:0]    m_next;
        logic [LOG_FRAC-1:0]  frac_next;

        always_comb begin
            sq        = m_reg[g] * m_reg[g];
            sh        = sq[2*LOG_FRAC+1:LOG_FRAC];
            m_next    = sh[MANT_W] ? sh[MANT_W:1] : sh[MANT_W-1:0];
            frac_next = {frac_reg[g][LOG_FRAC-2:0], sh[MANT_W]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[g+1] <= '0;
            end else if (en) begin
                ctl_reg[g+1] <= ctl_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[g+1]    <= x_reg[g];
                m_reg[g+1]    <= m_next;
                frac_reg[g+1] <= frac_next;
                p_reg[g+1]    <= p_reg[g];
            end
        end
    end

    assign pdiff   = LG_INT_W'(p_reg[NSTG]) - LG_INT_W'(FRAC_BITS);
    assign lg_out  = signed'({pdiff, frac_reg[NSTG]});
    assign ctl_out = ctl_reg[NSTG];
    assign x_out   = x_reg[NSTG];

endmodule

FILE: src/rte_exp2.sv
`timescale 1ns / 1ps

module rte_exp2 #(
    parameter int SAMPLE_BITS = 32,
    parameter int FRAC_BITS   = 28
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic [rte_pkg::CS_W-1:0]           mode,
    input  rte_pkg::rte_ctl_t                  ctl_in,
    input  logic signed [SAMPLE_BITS-1:0]      x_in,
    input  logic signed [rte_pkg::LG_W-1:0]    lg_in,
    output rte_pkg::rte_ctl_t                  ctl_out,
    output logic signed [SAMPLE_BITS-1:0]      x_out,
    output logic [SAMPLE_BITS-1:0]             pow_out
);
    import rte_pkg::*;

    localparam int NSTG  = LOG_FRAC;
    localparam int LO_W  = 19;
    localparam int HI_W  = LG_W - LO_W;
    localparam int QW    = LG_W + 1;
    localparam int YW    = QW + 1;
    localparam int NBW   = YW - LOG_FRAC;
    localparam int SW    = NBW + 1;
    localparam logic [63:0] SMAX64 = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    // P0: magnitude of log2
    rte_ctl_t                      ctl_p0_reg, ctl_p1_reg, ctl_p2_reg;
    logic signed [SAMPLE_BITS-1:0] x_p0_reg, x_p1_reg, x_p2_reg;
    logic                          sgn_p0_reg, sgn_p1_reg, sgn_p2_reg;
    logic [LG_W-1:0]               mag_p0_reg;
    logic [LO_W+EXP_W-1:0]         lo_p1_reg;
    logic [HI_W+EXP_W-1:0]         hi_p1_reg;
    logic [QW-1:0]                 q_p2_reg;
    logic [EXP_W-1:0]              e_sel;
    logic [63:0]                   prod_sum;
    logic signed [YW-1:0]          y_val;

    rte_ctl_t                      ctl_reg [0:NSTG];
    logic signed [SAMPLE_BITS-1:0] x_reg   [0:NSTG];
    logic [MANT_W-1:0]             r_reg   [0:NSTG];
    logic [LOG_FRAC-1:0]           f_reg   [0:NSTG];
    logic signed [NBW-1:0]         n_reg   [0:NSTG];

    rte_ctl_t                      ctl_f1_reg, ctl_f2_reg;
    logic signed [SAMPLE_BITS-1:0] x_f1_reg, x_f2_reg;
    logic [63:0]                   val_f1_reg;
    logic                          big_f1_reg, zero_f1_reg;
    logic [SAMPLE_BITS-1:0]        pow_f2_reg;

    logic signed [SW-1:0]          s_val;
    logic [4:0]                    amt_r;
    logic [63:0]                   shl_val, shr_val;
    logic [SAMPLE_BITS-1:0]        pow_next;

    assign e_sel    = power_exp(mode);
    assign prod_sum = 64'({hi_p1_reg, {LO_W{1'b0}}}) + 64'(lo_p1_reg) + (64'd1 << (EXP_W - 1));
    assign y_val    = sgn_p2_reg ? -signed'({1'b0, q_p2_reg}) : signed'({1'b0, q_p2_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_p0_reg <= '0;
            ctl_p1_reg <= '0;
            ctl_p2_reg <= '0;
            ctl_reg[0] <= '0;
        end else if (en) begin
            ctl_p0_reg <= ctl_in;
            ctl_p1_reg <= ctl_p0_reg;
            ctl_p2_reg <= ctl_p1_reg;
            ctl_reg[0] <= ctl_p2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_p0_reg   <= x_in;
            sgn_p0_reg <= lg_in[LG_W-1];
            mag_p0_reg <= lg_in[LG_W-1] ? LG_W'(-lg_in) : LG_W'(lg_in);
            x_p1_reg   <= x_p0_reg;
            sgn_p1_reg <= sgn_p0_reg;
            lo_p1_reg  <= mag_p0_reg[LO_W-1:0] * e_sel;
            hi_p1_reg  <= mag_p0_reg[LG_W-1:LO_W] * e_sel;
            x_p2_reg   <= x_p1_reg;
            sgn_p2_reg <= sgn_p1_reg;
            q_p2_reg   <= prod_sum[EXP_W+QW-1:EXP_W];
            x_reg[0]   <= x_p2_reg;
            r_reg[0]   <= ONE_Q30;
            f_reg[0]   <= y_val[LOG_FRAC-1:0];
            n_reg[0]   <= y_val[YW-1:LOG_FRAC];
        end
    end

    for (genvar g = 0; g < NSTG; g++) begin : g_mul
        localparam logic [MANT_W-1:0] TAB = exp_tab_entry(g + 1);
        logic [2*MANT_W-1:0] prod;
        logic [MANT_W-1:0]   r_next;

        always_comb begin
            prod   = r_reg[g] * TAB;
            r_next = f_reg[g][LOG_FRAC-1-g] ? prod[2*LOG_FRAC:LOG_FRAC] : r_reg[g];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[g+1] <= '0;
            end else if (en) begin
                ctl_reg[g+1] <= ctl_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[g+1] <= x_reg[g];
                r_reg[g+1] <= r_next;
                f_reg[g+1] <= f_reg[g];
                n_reg[g+1] <= n_reg[g];
            end
        end
    end

    always_comb begin
        s_val   = SW'(n_reg[NSTG]) + SW'(FRAC_BITS - LOG_FRAC);
        amt_r   = 5'(-s_val);
        shl_val = 64'(r_reg[NSTG]) << s_val[4:0];
        shr_val = (64'(r_reg[NSTG]) + (64'd1 << (amt_r - 5'd1))) >> amt_r;
    end

    always_comb begin
        if (zero_f1_reg) begin
            pow_next = '0;
        end else if (big_f1_reg || (val_f1_reg > SMAX64)) begin
            pow_next = SMAX64[SAMPLE_BITS-1:0];
        end else begin
            pow_next = val_f1_reg[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_f1_reg <= '0;
            ctl_f2_reg <= '0;
        end else if (en) begin
            ctl_f1_reg <= ctl_reg[NSTG];
            ctl_f2_reg <= ctl_f1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_f1_reg    <= x_reg[NSTG];
            val_f1_reg  <= s_val[SW-1] ? shr_val : shl_val;
            big_f1_reg  <= (s_val >= SW'(32));
            zero_f1_reg <= (s_val <= -SW'(32)) || !ctl_reg[NSTG].pos;
            x_f2_reg    <= x_f1_reg;
            pow_f2_reg  <= pow_next;
        end
    end

    assign ctl_out = ctl_f2_reg;
    assign x_out   = x_f2_reg;
    assign pow_out = pow_f2_reg;

endmodule

FILE: src/rte_encode.sv
`timescale 1ns / 1ps

module rte_encode #(
    parameter int SAMPLE_BITS = 32,
    parameter int FRAC_BITS   = 28
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [rte_pkg::CS_W-1:0]      mode,
    input  logic                          valid_in,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    input  logic [SAMPLE_BITS-1:0]        pow_in,
    output logic                          valid_out,
    output logic signed [SAMPLE_BITS-1:0] enc_out,
    output logic                          invalid_out
);
    import rte_pkg::*;

    localparam int HI_W = (SAMPLE_BITS > MULQ_W) ? SAMPLE_BITS - MULQ_W : 1;
    localparam int PW   = MULQ_W + CONST_W + SAMPLE_BITS;
    localparam logic signed [63:0] SMAX64 = signed'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [63:0] SMIN64 = -SMAX64 - 64'sd1;
    localparam logic signed [63:0] T_SRGB = kscale(K_SRGB_T, FRAC_BITS);
    localparam logic signed [63:0] T_BT   = kscale(K_BT_T, FRAC_BITS);
    localparam logic signed [63:0] T_PRO  = signed'(64'd1 << (FRAC_BITS - 9));
    localparam logic signed [63:0] O_SRGB = kscale(K_SRGB_OFF, FRAC_BITS);
    localparam logic signed [63:0] O_BT   = kscale(K_BT_OFF, FRAC_BITS);
    localparam logic [PW-1:0]      LIM    = PW'(1) << (SAMPLE_BITS - 1);

    logic signed [63:0]            xe;
    logic signed [SAMPLE_BITS-1:0] opnd_next;
    logic [CONST_W-1:0]            c_next;
    logic signed [63:0]            off_next;
    logic                          inv_next;
    logic                          lin;

    logic                          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [SAMPLE_BITS-1:0]        mag_s1_reg;
    logic                          neg_s1_reg, neg_s2_reg, neg_s3_reg;
    logic [CONST_W-1:0]            c_s1_reg;
    logic signed [63:0]            off_s1_reg, off_s2_reg, off_s3_reg, off_s4_reg;
    logic                          inv_s1_reg, inv_s2_reg, inv_s3_reg, inv_s4_reg, inv_s5_reg;
    logic [HI_W+CONST_W-1:0]       ph_s2_reg;
    logic [MULQ_W+CONST_W-1:0]     pl_s2_reg;
    logic [SAMPLE_BITS-1:0]        p_s3_reg;
    logic signed [SAMPLE_BITS-1:0] w_s4_reg;
    logic signed [SAMPLE_BITS-1:0] enc_s5_reg;

    logic [SAMPLE_BITS-1:0]        mag_sh;
    logic [PW-1:0]                 p_sum;
    logic [SAMPLE_BITS-1:0]        p_next;
    logic signed [SAMPLE_BITS:0]   w_ext;
    logic signed [SAMPLE_BITS-1:0] w_next;
    logic signed [63:0]            d_val;
    logic signed [SAMPLE_BITS-1:0] enc_next;

    assign xe = 64'(x_in);

    always_comb begin
        opnd_next = x_in;
        c_next    = M_ONE;
        off_next  = '0;
        inv_next  = 1'b0;
        lin       = 1'b0;
        unique case (mode)
            CS_ADOBE: begin
                if (x_in < 0) begin
                    opnd_next = '0;
                    inv_next  = 1'b1;
                end else begin
                    opnd_next = signed'(pow_in);
                end
            end
            CS_PROPHOTO: begin
                lin       = (xe < T_PRO);
                opnd_next = lin ? x_in : signed'(pow_in);
                c_next    = lin ? M_16 : M_ONE;
            end
            CS_BT2020: begin
                lin       = (xe < T_BT);
                opnd_next = lin ? x_in : signed'(pow_in);
                c_next    = lin ? M_45 : M_1099;
                off_next  = lin ? 64'sd0 : O_BT;
            end
            CS_ACES: begin
                opnd_next = x_in;
            end
            default: begin
                lin       = (xe <= T_SRGB);
                opnd_next = lin ? x_in : signed'(pow_in);
                c_next    = lin ? M_1292 : M_1055;
                off_next  = lin ? 64'sd0 : O_SRGB;
            end
        endcase
    end

    always_comb begin
        mag_sh = mag_s1_reg >> MULQ_W;
        p_sum  = PW'(ph_s2_reg) + ((PW'(pl_s2_reg) + (PW'(1) << (MULQ_W - 1))) >> MULQ_W);
        p_next = (p_sum > LIM) ? LIM[SAMPLE_BITS-1:0] : p_sum[SAMPLE_BITS-1:0];
        w_ext  = neg_s3_reg ? -signed'({1'b0, p_s3_reg}) : signed'({1'b0, p_s3_reg});
        w_next = (64'(w_ext) > SMAX64) ? SMAX64[SAMPLE_BITS-1:0] : w_ext[SAMPLE_BITS-1:0];
        d_val  = 64'(w_s4_reg) - off_s4_reg;
        if (d_val > SMAX64) begin
            enc_next = SMAX64[SAMPLE_BITS-1:0];
        end else if (d_val < SMIN64) begin
            enc_next = SMIN64[SAMPLE_BITS-1:0];
        end else begin
            enc_next = d_val[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_s1_reg <= opnd_next[SAMPLE_BITS-1] ? SAMPLE_BITS'(-opnd_next) : opnd_next;
            neg_s1_reg <= opnd_next[SAMPLE_BITS-1];
            c_s1_reg   <= c_next;
            off_s1_reg <= off_next;
            inv_s1_reg <= inv_next;
            ph_s2_reg  <= HI_W'(mag_sh) * c_s1_reg;
            pl_s2_reg  <= MULQ_W'(mag_s1_reg) * c_s1_reg;
            neg_s2_reg <= neg_s1_reg;
            off_s2_reg <= off_s1_reg;
            inv_s2_reg <= inv_s1_reg;
            p_s3_reg   <= p_next;
            neg_s3_reg <= neg_s2_reg;
            off_s3_reg <= off_s2_reg;
            inv_s3_reg <= inv_s2_reg;
            w_s4_reg   <= w_next;
            off_s4_reg <= off_s3_reg;
            inv_s4_reg <= inv_s3_reg;
            enc_s5_reg <= enc_next;
            inv_s5_reg <= inv_s4_reg;
        end
    end

    assign valid_out   = v5_reg;
    assign enc_out     = enc_s5_reg;
    assign invalid_out = inv_s5_reg;

endmodule

FILE: src/rgb_transfer_encode_core.sv
// Throughput: one transfer per cycle while the output skid is empty;
// 30 squaring stages and 30 exp2 multiply stages each hold one item, and a
// two-entry output skid keeps s_ready registered.
// Reset: synchronous, active low; clears all valid bits and color_space to sRGB.
`timescale 1ns / 1ps

module rgb_transfer_encode_core #(
    parameter int SAMPLE_BITS = 32,
    parameter int FRAC_BITS   = 28
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rte_pkg::CS_W-1:0]      cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_linear_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_encoded_value,
    output logic                          m_invalid
);
    import rte_pkg::*;

    logic [CS_W-1:0]               color_space_reg;
    logic                          en;
    rte_ctl_t                      ctl_s0_reg;
    logic signed [SAMPLE_BITS-1:0] x_s0_reg;

    rte_ctl_t                      ctl_lg;
    logic signed [SAMPLE_BITS-1:0] x_lg;
    logic signed [LG_W-1:0]        lg_val;
    rte_ctl_t                      ctl_ex;
    logic signed [SAMPLE_BITS-1:0] x_ex;
    logic [SAMPLE_BITS-1:0]        pow_ex;
    logic                          enc_valid;
    logic signed [SAMPLE_BITS-1:0] enc_val;
    logic                          enc_inv;
    logic                          incoming;

    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_enc_reg;
    logic                          m_inv_reg;
    logic                          skid_valid_reg;
    logic signed [SAMPLE_BITS-1:0] skid_enc_reg;
    logic                          skid_inv_reg;

    assign en       = !skid_valid_reg;
    assign s_ready  = en;
    assign incoming = enc_valid && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_space_reg <= CS_SRGB;
        end else if (cfg_wr_en) begin
            color_space_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_s0_reg <= '0;
        end else if (en) begin
            ctl_s0_reg.valid <= s_valid;
            ctl_s0_reg.pos   <= (s_linear_value > 0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_s0_reg <= s_linear_value;
        end
    end

    rte_log2 #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_log2 (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (en),
        .ctl_in (ctl_s0_reg),
        .x_in   (x_s0_reg),
        .ctl_out(ctl_lg),
        .x_out  (x_lg),
        .lg_out (lg_val)
    );

    rte_exp2 #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_exp2 (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (en),
        .mode   (color_space_reg),
        .ctl_in (ctl_lg),
        .x_in   (x_lg),
        .lg_in  (lg_val),
        .ctl_out(ctl_ex),
        .x_out  (x_ex),
        .pow_out(pow_ex)
    );

    rte_encode #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_encode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .mode       (color_space_reg),
        .valid_in   (ctl_ex.valid),
        .x_in       (x_ex),
        .pow_in     (pow_ex),
        .valid_out  (enc_valid),
        .enc_out    (enc_val),
        .invalid_out(enc_inv)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= incoming;
        end else if (incoming) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                m_enc_reg <= skid_enc_reg;
                m_inv_reg <= skid_inv_reg;
            end
        end else if (!m_valid_reg || m_ready) begin
            if (incoming) begin
                m_enc_reg <= enc_val;
                m_inv_reg <= enc_inv;
            end
        end else if (incoming) begin
            skid_enc_reg <= enc_val;
            skid_inv_reg <= enc_inv;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_encoded_value = m_enc_reg;
    assign m_invalid       = m_inv_reg;

endmodule

FILE: src/rte_checker.sv
`timescale 1ns / 1ps

module rte_checker #(
    parameter int SAMPLE_BITS = 32
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_wr_en,
    input logic [rte_pkg::CS_W-1:0]      cfg_wr_data,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_encoded_value,
    input logic                          m_invalid
);
    import rte_pkg::*;

    logic [CS_W-1:0] mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= CS_SRGB;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_encoded_value) && $stable(m_invalid))
        else $error("result transfer changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_invalid |-> m_encoded_value == '0)
        else $error("invalid result carries a nonzero value");

    a_invalid_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_invalid |-> mode_reg == CS_ADOBE)
        else $error("invalid flag outside Adobe mode");

endmodule

bind rgb_transfer_encode_core rte_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_rte_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_encoded_value(m_encoded_value),
    .m_invalid      (m_invalid)
);
